[src/cbrd_pkg.sv]
`default_nettype none
package cbrd_pkg;

    localparam logic [3:0] VERSION_RESET   = 4'd9;
    localparam logic [3:0] VERSION_LIST    = 4'd7;
    localparam logic [3:0] VERSION_FLAGS   = 4'd8;
    localparam logic [7:0] TYPE_SPARSE     = 8'd1;
    localparam logic [7:0] TYPE_DENSE      = 8'd2;
    localparam logic [15:0] SHORT_SENTINEL = 16'h8000;

    localparam int FL_SHORT_CNT = 0;
    localparam int FL_SHORT_X   = 1;
    localparam int FL_SHORT_Y   = 2;

    localparam logic KIND_RECORD = 1'b0;
    localparam logic KIND_MARKER = 1'b1;

    typedef struct packed {
        logic [31:0] count;
        logic [31:0] bin_y;
        logic [31:0] bin_x;
        logic [15:0] chromosome;
        logic        kind;
    } result_t;

    typedef struct packed {
        logic    rec_valid;
        logic    mark_valid;
        result_t rec;
    } push_t;

    // IEEE single to int32, truncate toward zero, saturate; NaN gives zero
    function automatic logic [31:0] float_to_count(input logic [31:0] b);
        logic [7:0]  e;
        logic [31:0] mag;
        e = b[30:23];
        mag = {8'd0, 1'b1, b[22:0]};
        if (e == 8'hFF && b[22:0] != 23'd0)
            return 32'd0;
        if (e < 8'd127)
            return 32'd0;
        if (e >= 8'd158)
            return b[31] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        if (e >= 8'd150)
            mag = mag << (e - 8'd150);
        else
            mag = mag >> (8'd150 - e);
        return b[31] ? (32'd0 - mag) : mag;
    endfunction

endpackage
`default_nettype wire

[src/cbrd_parser.sv]
`default_nettype none
module cbrd_parser (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [3:0]        cfg_wdata,
    input  wire logic              beat,
    input  wire logic [7:0]        data_byte,
    input  wire logic              block_start,
    input  wire logic [15:0]       chrom_id,
    output cbrd_pkg::push_t        push
);

    typedef enum logic [4:0] {
        PH_IDLE, PH_NREC, PH_XOFF, PH_YOFF, PH_FSHORT, PH_FX, PH_FY, PH_TYPE,
        PH_LBX, PH_LBY, PH_LCNT, PH_SROWS, PH_SROWBIN, PH_SCOLS, PH_SCOLBIN,
        PH_SCNT, PH_DNPTS, PH_DWIDTH, PH_DCNT
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [2:0]  bidx_reg, bidx_next;
    logic [31:0] shift_reg, shift_next;
    logic [15:0] chrom_reg, chrom_next;
    logic [31:0] xoff_reg, xoff_next, yoff_reg, yoff_next;
    logic [2:0]  flags_reg, flags_next;
    logic [31:0] outer_reg, outer_next, inner_reg, inner_next;
    logic [31:0] row_reg, row_next, col_reg, col_next;
    logic [15:0] gwidth_reg, gwidth_next, gcol_reg, gcol_next;
    logic [31:0] grow_reg, grow_next;
    logic [3:0]  version_reg;

    always_comb
    begin
        phase_t      ph;
        logic [2:0]  len;
        logic [2:0]  bi;
        logic [31:0] v;
        logic [31:0] sv;
        logic [31:0] cnt;
        logic [31:0] outer_dec;
        logic [15:0] gcol_inc;
        logic        keep;
        logic        wpos;
        phase_next  = phase_reg;
        bidx_next   = bidx_reg;
        shift_next  = shift_reg;
        chrom_next  = chrom_reg;
        xoff_next   = xoff_reg;
        yoff_next   = yoff_reg;
        flags_next  = flags_reg;
        outer_next  = outer_reg;
        inner_next  = inner_reg;
        row_next    = row_reg;
        col_next    = col_reg;
        gwidth_next = gwidth_reg;
        gcol_next   = gcol_reg;
        grow_next   = grow_reg;
        push        = '0;
        ph          = phase_reg;
        len         = 3'd4;
        v           = '0;
        sv          = '0;
        cnt         = '0;
        outer_dec   = outer_reg - 32'd1;
        gcol_inc    = gcol_reg + 16'd1;
        keep        = 1'b0;
        wpos        = 1'b0;
        bi          = bidx_reg;
        if (beat)
        begin
            if (block_start)
            begin
                chrom_next = chrom_id;
                ph         = PH_NREC;
                bi         = 3'd0;
                shift_next = '0;
                flags_next = 3'b111;
            end
            if (ph == PH_IDLE)
            begin
                phase_next = PH_IDLE;
                bidx_next  = bi;
            end
            else
            begin
                phase_next = ph;
                case (ph)
                    PH_FSHORT, PH_FX, PH_FY, PH_TYPE: len = 3'd1;
                    PH_SROWS, PH_SROWBIN: len = flags_next[cbrd_pkg::FL_SHORT_Y] ? 3'd2 : 3'd4;
                    PH_SCOLS, PH_SCOLBIN: len = flags_next[cbrd_pkg::FL_SHORT_X] ? 3'd2 : 3'd4;
                    PH_SCNT, PH_DCNT: len = flags_next[cbrd_pkg::FL_SHORT_CNT] ? 3'd2 : 3'd4;
                    PH_DWIDTH: len = 3'd2;
                    default: len = 3'd4;
                endcase
                v  = shift_next | ({24'd0, data_byte} << {bi[1:0], 3'b000});
                bi = bi + 3'd1;
                shift_next = v;
                bidx_next  = bi;
                if (bi >= len)
                begin
                    bidx_next  = 3'd0;
                    shift_next = '0;
                    sv  = (len == 3'd2) ? {{16{v[15]}}, v[15:0]} : v;
                    cnt = (len == 3'd2) ? sv : cbrd_pkg::float_to_count(v);
                    push.rec.kind       = cbrd_pkg::KIND_RECORD;
                    push.rec.chromosome = chrom_next;
                    push.rec.bin_x      = col_reg;
                    push.rec.bin_y      = row_reg;
                    push.rec.count      = cnt;
                    case (ph)
                        PH_NREC:
                        begin
                            if (version_reg < cbrd_pkg::VERSION_LIST)
                            begin
                                outer_next = v;
                                if (v != 0 && !v[31])
                                    phase_next = PH_LBX;
                                else
                                    push.mark_valid = 1'b1;
                            end
                            else
                                phase_next = PH_XOFF;
                        end
                        PH_XOFF:
                        begin
                            xoff_next  = v;
                            phase_next = PH_YOFF;
                        end
                        PH_YOFF:
                        begin
                            yoff_next  = v;
                            phase_next = PH_FSHORT;
                        end
                        PH_FSHORT:
                        begin
                            flags_next = (v == 0) ? 3'b111 : 3'b110;
                            phase_next = (version_reg > cbrd_pkg::VERSION_FLAGS) ? PH_FX
                                                                                  : PH_TYPE;
                        end
                        PH_FX:
                        begin
                            if (v != 0)
                                flags_next[cbrd_pkg::FL_SHORT_X] = 1'b0;
                            phase_next = PH_FY;
                        end
                        PH_FY:
                        begin
                            if (v != 0)
                                flags_next[cbrd_pkg::FL_SHORT_Y] = 1'b0;
                            phase_next = PH_TYPE;
                        end
                        PH_TYPE:
                        begin
                            if (v == {24'd0, cbrd_pkg::TYPE_SPARSE})
                                phase_next = PH_SROWS;
                            else if (v == {24'd0, cbrd_pkg::TYPE_DENSE})
                                phase_next = PH_DNPTS;
                            else
                                push.mark_valid = 1'b1;
                        end
                        PH_LBX:
                        begin
                            col_next   = v;
                            phase_next = PH_LBY;
                        end
                        PH_LBY:
                        begin
                            row_next   = v;
                            phase_next = PH_LCNT;
                        end
                        PH_LCNT:
                        begin
                            push.rec_valid = 1'b1;
                            outer_next     = outer_dec;
                            if (outer_dec == 0)
                                push.mark_valid = 1'b1;
                            else
                                phase_next = PH_LBX;
                        end
                        PH_SROWS:
                        begin
                            outer_next = sv;
                            if (sv != 0 && !sv[31])
                                phase_next = PH_SROWBIN;
                            else
                                push.mark_valid = 1'b1;
                        end
                        PH_SROWBIN:
                        begin
                            row_next   = yoff_reg + sv;
                            phase_next = PH_SCOLS;
                        end
                        PH_SCOLS:
                        begin
                            if (sv != 0 && !sv[31])
                            begin
                                inner_next = sv;
                                phase_next = PH_SCOLBIN;
                            end
                            else
                            begin
                                inner_next = '0;
                                outer_next = outer_dec;
                                if (outer_dec == 0)
                                    push.mark_valid = 1'b1;
                                else
                                    phase_next = PH_SROWBIN;
                            end
                        end
                        PH_SCOLBIN:
                        begin
                            col_next   = xoff_reg + sv;
                            phase_next = PH_SCNT;
                        end
                        PH_SCNT:
                        begin
                            push.rec_valid = 1'b1;
                            inner_next     = inner_reg - 32'd1;
                            if (inner_reg != 32'd1)
                                phase_next = PH_SCOLBIN;
                            else
                            begin
                                outer_next = outer_dec;
                                if (outer_dec == 0)
                                    push.mark_valid = 1'b1;
                                else
                                    phase_next = PH_SROWBIN;
                            end
                        end
                        PH_DNPTS:
                        begin
                            outer_next = v;
                            phase_next = PH_DWIDTH;
                        end
                        PH_DWIDTH:
                        begin
                            gwidth_next = v[15:0];
                            gcol_next   = '0;
                            grow_next   = '0;
                            if (outer_reg != 0 && !outer_reg[31])
                                phase_next = PH_DCNT;
                            else
                                push.mark_valid = 1'b1;
                        end
                        PH_DCNT:
                        begin
                            keep = (len == 3'd2) ? (v != {16'd0, cbrd_pkg::SHORT_SENTINEL})
                                                 : !(v[30:23] == 8'hFF && v[22:0] != 23'd0);
                            push.rec_valid = keep;
                            push.rec.bin_x = xoff_reg + {16'd0, gcol_reg};
                            push.rec.bin_y = yoff_reg + grow_reg;
                            wpos = (gwidth_reg != 16'd0) && !gwidth_reg[15];
                            gcol_next = gcol_inc;
                            // wrap the column at the grid width, or at the 16-bit limit
                            if ((wpos && gcol_inc == gwidth_reg) || gcol_inc == 16'd0)
                            begin
                                gcol_next = '0;
                                grow_next = grow_reg + 32'd1;
                            end
                            outer_next = outer_dec;
                            if (outer_dec == 0)
                                push.mark_valid = 1'b1;
                        end
                        default: phase_next = PH_IDLE;
                    endcase
                    if (push.mark_valid)
                        phase_next = PH_IDLE;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            bidx_reg    <= '0;
            shift_reg   <= '0;
            chrom_reg   <= '0;
            xoff_reg    <= '0;
            yoff_reg    <= '0;
            flags_reg   <= 3'b111;
            outer_reg   <= '0;
            inner_reg   <= '0;
            row_reg     <= '0;
            col_reg     <= '0;
            gwidth_reg  <= '0;
            gcol_reg    <= '0;
            grow_reg    <= '0;
            version_reg <= cbrd_pkg::VERSION_RESET;
        end
        else
        begin
            phase_reg  <= phase_next;
            bidx_reg   <= bidx_next;
            shift_reg  <= shift_next;
            chrom_reg  <= chrom_next;
            xoff_reg   <= xoff_next;
            yoff_reg   <= yoff_next;
            flags_reg  <= flags_next;
            outer_reg  <= outer_next;
            inner_reg  <= inner_next;
            row_reg    <= row_next;
            col_reg    <= col_next;
            gwidth_reg <= gwidth_next;
            gcol_reg   <= gcol_next;
            grow_reg   <= grow_next;
            if (cfg_we)
                version_reg <= cfg_wdata;
        end
    end

endmodule
`default_nettype wire

[src/cbrd_fifo.sv]
`default_nettype none
module cbrd_fifo (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  cbrd_pkg::push_t        push,
    input  wire logic              pop,
    output cbrd_pkg::result_t      head,
    output logic                   not_empty,
    output logic [2:0]             level
);

    cbrd_pkg::result_t mem [4];
    logic [1:0] wr_ptr_reg, rd_ptr_reg;
    logic [2:0] level_reg;
    cbrd_pkg::result_t marker, first;
    logic [1:0] n_push;

    always_comb
    begin
        marker      = '0;
        marker.kind = cbrd_pkg::KIND_MARKER;
        first       = push.rec_valid ? push.rec : marker;
        n_push      = {1'b0, push.rec_valid} + {1'b0, push.mark_valid};
    end

    // hold up to two pushes per beat: record first, then end marker
    always_ff @(posedge clk)
    begin
        if (n_push != 2'd0)
            mem[wr_ptr_reg] <= first;
        if (n_push == 2'd2)
            mem[wr_ptr_reg + 2'd1] <= marker;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + n_push;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            level_reg <= level_reg + {1'b0, n_push} - {2'b00, pop};
        end
    end

    assign head      = mem[rd_ptr_reg];
    assign not_empty = (level_reg != 3'd0);
    assign level     = level_reg;

endmodule
`default_nettype wire

[src/contact_block_record_decoder.sv]
`default_nettype none
// Contact block record decoder: takes the inflated bytes of one contact-matrix block, one
// byte per beat, parses the version-dependent header and emits one result beat per contact,
// followed by an end-of-block marker (tuser = 1). A byte is taken every cycle while the
// four-entry result queue has room for two results; the queue drains one beat per cycle while
// m_axis_tready is high, so a byte that yields a record and the marker takes two entries.
module contact_block_record_decoder (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_we,
    input  wire logic [3:0]   cfg_wdata,       // format_version
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [23:0]  s_axis_tdata,    // data_byte[7:0], chrom_id[23:8]
    input  wire logic         s_axis_tuser,    // block_start
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [111:0]      m_axis_tdata,    // chromosome, bin_x, bin_y, count
    output logic              m_axis_tuser     // kind
);

    cbrd_pkg::push_t   push;
    cbrd_pkg::result_t head;
    logic              beat;
    logic              pop;
    logic              not_empty;
    logic [2:0]        level;

    assign s_axis_tready = (level <= 3'd2);
    assign beat          = s_axis_tvalid && s_axis_tready;
    assign pop           = not_empty && m_axis_tready;

    cbrd_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .beat        (beat),
        .data_byte   (s_axis_tdata[7:0]),
        .block_start (s_axis_tuser),
        .chrom_id    (s_axis_tdata[23:8]),
        .push        (push)
    );

    cbrd_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .pop       (pop),
        .head      (head),
        .not_empty (not_empty),
        .level     (level)
    );

    assign m_axis_tvalid = not_empty;
    assign m_axis_tuser  = head.kind;
    assign m_axis_tdata  = {head.count, head.bin_y, head.bin_x, head.chromosome};

`ifndef SYNTHESIS
    a_level_max: assert property (@(posedge clk) disable iff (!rst_n) level <= 3'd4)
        else $error("result queue overflow");
    a_push_only_on_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (push.rec_valid || push.mark_valid) |-> beat)
        else $error("result pushed without an input beat");
    a_marker_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == 112'd0))
        else $error("end marker carries payload");
`endif

endmodule
`default_nettype wire

[test/cbrd_record_checker.sv]
module cbrd_record_checker (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_we,
    input  wire logic [3:0]   cfg_wdata,
    input  wire logic         s_axis_tvalid,
    input  wire logic         s_axis_tready,
    input  wire logic [23:0]  s_axis_tdata,
    input  wire logic         s_axis_tuser,
    input  wire logic         m_axis_tvalid,
    input  wire logic         m_axis_tready,
    input  wire logic [111:0] m_axis_tdata,
    input  wire logic         m_axis_tuser,
    output int                errors,
    output int                pending,
    output int                records_seen,
    output int                markers_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [4:0] {
        P_IDLE, P_NREC, P_XOFF, P_YOFF, P_FSHORT, P_FX, P_FY, P_TYPE,
        P_LBX, P_LBY, P_LCNT, P_SROWS, P_SROWBIN, P_SCOLS, P_SCOLBIN, P_SCNT,
        P_DNPTS, P_DWIDTH, P_DCNT
    } phase_t;

    logic [3:0]  version;
    phase_t      phase;
    logic [2:0]  nbytes;
    logic [31:0] accum;
    logic [15:0] chrom;
    logic [31:0] xoff, yoff;
    logic [2:0]  flags;
    logic [31:0] outer_left, inner_left, row_bin, col_bin;
    logic [15:0] width, column;
    logic [31:0] row;
    cbrd_pkg::result_t expected_records[$];

    function automatic logic positive(input logic [31:0] v);
        return v != 32'd0 && !v[31];
    endfunction

    function automatic logic [31:0] widen(input logic [31:0] v, input int len);
        return (len == 2) ? {{16{v[15]}}, v[15:0]} : v;
    endfunction

    // truncate toward zero, saturate beyond 32 bits and on infinity, NaN to zero
    function automatic logic [31:0] float_count(input logic [31:0] f);
        int          ex;
        logic [63:0] m;
        ex = int'(f[30:23]);
        if (ex == 255 && f[22:0] != 23'd0)
            return 32'd0;
        if (ex < 127)
            return 32'd0;
        if (ex >= 158)
            return f[31] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        m = {40'd0, 1'b1, f[22:0]};
        m = (ex >= 150) ? (m << (ex - 150)) : (m >> (150 - ex));
        return f[31] ? -m[31:0] : m[31:0];
    endfunction

    function automatic int field_width(input phase_t p, input logic [2:0] fl);
        case (p)
            P_FSHORT, P_FX, P_FY, P_TYPE: return 1;
            P_SROWS, P_SROWBIN:           return fl[cbrd_pkg::FL_SHORT_Y] ? 2 : 4;
            P_SCOLS, P_SCOLBIN:           return fl[cbrd_pkg::FL_SHORT_X] ? 2 : 4;
            P_SCNT, P_DCNT:               return fl[cbrd_pkg::FL_SHORT_CNT] ? 2 : 4;
            P_DWIDTH:                     return 2;
            default:                      return 4;
        endcase
    endfunction

    task automatic add_result(input logic k, input logic [15:0] c, input logic [31:0] bx,
                              input logic [31:0] by, input logic [31:0] n);
        cbrd_pkg::result_t r;
        r.kind = k;
        r.chromosome = c;
        r.bin_x = bx;
        r.bin_y = by;
        r.count = n;
        expected_records.insert(expected_records.size(), r);
    endtask

    task automatic end_block();
        add_result(cbrd_pkg::KIND_MARKER, 16'd0, 32'd0, 32'd0, 32'd0);
        phase = P_IDLE;
    endtask

    task automatic close_row();
        outer_left = outer_left - 32'd1;
        if (outer_left == 32'd0)
            end_block();
        else
            phase = P_SROWBIN;
    endtask

    task automatic take_field(input logic [31:0] v, input int len);
        logic [31:0] sv;
        logic [31:0] w;
        logic        keep;
        sv = widen(v, len);
        case (phase)
            P_NREC:
                if (version < cbrd_pkg::VERSION_LIST)
                begin
                    outer_left = v;
                    if (positive(v))
                        phase = P_LBX;
                    else
                        end_block();
                end
                else
                    phase = P_XOFF;
            P_XOFF:
            begin
                xoff = v;
                phase = P_YOFF;
            end
            P_YOFF:
            begin
                yoff = v;
                phase = P_FSHORT;
            end
            P_FSHORT:
            begin
                flags = (v == 32'd0) ? 3'b111 : 3'b110;
                phase = (version > cbrd_pkg::VERSION_FLAGS) ? P_FX : P_TYPE;
            end
            P_FX:
            begin
                if (v != 32'd0)
                    flags[cbrd_pkg::FL_SHORT_X] = 1'b0;
                phase = P_FY;
            end
            P_FY:
            begin
                if (v != 32'd0)
                    flags[cbrd_pkg::FL_SHORT_Y] = 1'b0;
                phase = P_TYPE;
            end
            P_TYPE:
                if (v[7:0] == cbrd_pkg::TYPE_SPARSE)
                    phase = P_SROWS;
                else if (v[7:0] == cbrd_pkg::TYPE_DENSE)
                    phase = P_DNPTS;
                else
                    end_block();
            P_LBX:
            begin
                col_bin = v;
                phase = P_LBY;
            end
            P_LBY:
            begin
                row_bin = v;
                phase = P_LCNT;
            end
            P_LCNT:
            begin
                add_result(cbrd_pkg::KIND_RECORD, chrom, col_bin, row_bin, float_count(v));
                outer_left = outer_left - 32'd1;
                if (outer_left == 32'd0)
                    end_block();
                else
                    phase = P_LBX;
            end
            P_SROWS:
            begin
                outer_left = sv;
                if (positive(sv))
                    phase = P_SROWBIN;
                else
                    end_block();
            end
            P_SROWBIN:
            begin
                row_bin = yoff + sv;
                phase = P_SCOLS;
            end
            P_SCOLS:
                if (positive(sv))
                begin
                    inner_left = sv;
                    phase = P_SCOLBIN;
                end
                else
                begin
                    inner_left = 32'd0;
                    close_row();
                end
            P_SCOLBIN:
            begin
                col_bin = xoff + sv;
                phase = P_SCNT;
            end
            P_SCNT:
            begin
                add_result(cbrd_pkg::KIND_RECORD, chrom, col_bin, row_bin,
                           (len == 2) ? sv : float_count(v));
                inner_left = inner_left - 32'd1;
                if (inner_left != 32'd0)
                    phase = P_SCOLBIN;
                else
                    close_row();
            end
            P_DNPTS:
            begin
                outer_left = v;
                phase = P_DWIDTH;
            end
            P_DWIDTH:
            begin
                width = v[15:0];
                column = 16'd0;
                row = 32'd0;
                if (positive(outer_left))
                    phase = P_DCNT;
                else
                    end_block();
            end
            P_DCNT:
            begin
                if (len == 2)
                    keep = v[15:0] != cbrd_pkg::SHORT_SENTINEL;
                else
                    keep = !(v[30:23] == 8'hFF && v[22:0] != 23'd0);
                w = {{16{width[15]}}, width};
                // skip sentinel and NaN cells but still advance the grid position
                if (keep)
                    add_result(cbrd_pkg::KIND_RECORD, chrom, xoff + {16'd0, column},
                               yoff + row, (len == 2) ? sv : float_count(v));
                column = column + 16'd1;
                if ((positive(w) && column == w[15:0]) || column == 16'd0)
                begin
                    column = 16'd0;
                    row = row + 32'd1;
                end
                outer_left = outer_left - 32'd1;
                if (outer_left == 32'd0)
                    end_block();
            end
            default:
                phase = P_IDLE;
        endcase
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic start, input logic [15:0] c);
        int len;
        if (start)
        begin
            chrom = c;
            phase = P_NREC;
            nbytes = 3'd0;
            accum = 32'd0;
            flags = 3'b111;
        end
        if (phase != P_IDLE)
        begin
            len = field_width(phase, flags);
            accum = accum | ({24'd0, b} << (nbytes[1:0] * 8));
            nbytes = nbytes + 3'd1;
            if (nbytes >= len)
            begin
                nbytes = 3'd0;
                take_field(accum, len);
                accum = 32'd0;
            end
        end
    endtask

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
        errors = errors + 1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        cbrd_pkg::result_t e;
        cbrd_pkg::result_t g;
        if (!rst_n)
        begin
            version = cbrd_pkg::VERSION_RESET;
            phase = P_IDLE;
            nbytes = 3'd0;
            accum = 32'd0;
            chrom = 16'd0;
            xoff = 32'd0;
            yoff = 32'd0;
            flags = 3'b111;
            outer_left = 32'd0;
            inner_left = 32'd0;
            row_bin = 32'd0;
            col_bin = 32'd0;
            width = 16'd0;
            column = 16'd0;
            row = 32'd0;
            expected_records.delete();
            errors = 0;
            records_seen = 0;
            markers_seen = 0;
        end
        else
        begin
            if (cfg_we)
                version = cfg_wdata;
            if (s_axis_tvalid && s_axis_tready)
                decode_byte(s_axis_tdata[7:0], s_axis_tuser, s_axis_tdata[23:8]);
            if (m_axis_tvalid && m_axis_tready)
            begin
                g.kind = m_axis_tuser;
                g.chromosome = m_axis_tdata[15:0];
                g.bin_x = m_axis_tdata[47:16];
                g.bin_y = m_axis_tdata[79:48];
                g.count = m_axis_tdata[111:80];
                if (g.kind == cbrd_pkg::KIND_MARKER)
                    markers_seen = markers_seen + 1;
                else
                    records_seen = records_seen + 1;
                if (expected_records.size() == 0)
                    report("unexpected beat, kind", {31'd0, g.kind}, 32'd0);
                else
                begin
                    e = expected_records.pop_front();
                    if (g.kind != e.kind)
                        report("kind", {31'd0, g.kind}, {31'd0, e.kind});
                    if (g.chromosome != e.chromosome)
                        report("chromosome", {16'd0, g.chromosome}, {16'd0, e.chromosome});
                    if (g.bin_x != e.bin_x)
                        report("bin_x", g.bin_x, e.bin_x);
                    if (g.bin_y != e.bin_y)
                        report("bin_y", g.bin_y, e.bin_y);
                    if (g.count != e.count)
                        report("count", g.count, e.count);
                end
            end
        end
        pending = expected_records.size();
    end

endmodule

[test/tb_top.sv]
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         cfg_we = 1'b0;
    logic [3:0]   cfg_wdata = 4'd0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [23:0]  s_axis_tdata = 24'd0;
    logic         s_axis_tuser = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [111:0] m_axis_tdata;
    logic         m_axis_tuser;
    int           errors, pending, records_seen, markers_seen;

    int           send_idle = 0;
    int           recv_idle = 0;
    int           bytes_sent = 0;
    int           blocks_sent = 0;
    logic [7:0]   block_bytes[$];

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    contact_block_record_decoder dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    cbrd_record_checker u_record_check (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .errors(errors), .pending(pending), .records_seen(records_seen),
        .markers_seen(markers_seen)
    );

    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= recv_idle);

    initial
    begin
        #3ms;
        $display("FAILED: results differ");
        $finish;
    end

    task automatic send_byte(input logic [7:0] b, input logic start, input logic [15:0] c);
        while ($urandom_range(99) < send_idle)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {c, b};
        s_axis_tuser <= start;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic drain();
        int n;
        n = 0;
        s_axis_tvalid <= 1'b0;
        while (pending != 0 && n < 20000)
        begin
            @(posedge clk);
            n++;
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic write_version(input logic [3:0] v);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic put(input logic [31:0] v, input int len);
        for (int i = 0; i < len; i++)
            block_bytes.insert(block_bytes.size(), v[8*i +: 8]);
    endtask

    function automatic logic [31:0] rand_float();
        logic [31:0] f;
        f = $urandom;
        case ($urandom_range(7))
            0: f[30:23] = 8'hFF;
            1: f[30:0] = {8'hFF, 23'd0};
            2: f[30:23] = 8'($urandom_range(126));
            3: f[30:23] = 8'($urandom_range(254, 158));
            default: f[30:23] = 8'($urandom_range(157, 127));
        endcase
        return f;
    endfunction

    function automatic logic [31:0] small_count(input int len, input int top);
        case ($urandom_range(9))
            0: return 32'd0;
            1: return (len == 2) ? {16'd0, 1'b1, 15'($urandom)} : {1'b1, 31'($urandom)};
            default: return $urandom_range(top, 1);
        endcase
    endfunction

    function automatic logic [31:0] rand_bin();
        return ($urandom_range(3) == 0) ? $urandom : $urandom_range(5000);
    endfunction

    // build one block for the given version into block_bytes
    task automatic build_block(input logic [3:0] ver);
        logic [31:0] n, rows, cols, cells;
        int          cl, xl, yl;
        logic [7:0]  kind_byte;
        block_bytes.delete();
        if (ver < cbrd_pkg::VERSION_LIST)
        begin
            n = small_count(4, 4);
            put(n, 4);
            if (!n[31])
                for (int i = 0; i < n; i++)
                begin
                    put(rand_bin(), 4);
                    put(rand_bin(), 4);
                    put(rand_float(), 4);
                end
            return;
        end
        put($urandom, 4);
        put(rand_bin(), 4);
        put(rand_bin(), 4);
        cl = $urandom_range(1) ? 2 : 4;
        put((cl == 2) ? 32'd0 : $urandom_range(255, 1), 1);
        xl = 2;
        yl = 2;
        if (ver > cbrd_pkg::VERSION_FLAGS)
        begin
            xl = $urandom_range(1) ? 2 : 4;
            yl = $urandom_range(1) ? 2 : 4;
            put((xl == 2) ? 32'd0 : $urandom_range(255, 1), 1);
            put((yl == 2) ? 32'd0 : $urandom_range(255, 1), 1);
        end
        case ($urandom_range(9))
            0: kind_byte = 8'($urandom);
            1, 2, 3, 4: kind_byte = cbrd_pkg::TYPE_SPARSE;
            default: kind_byte = cbrd_pkg::TYPE_DENSE;
        endcase
        put({24'd0, kind_byte}, 1);
        if (kind_byte == cbrd_pkg::TYPE_SPARSE)
        begin
            rows = small_count(yl, 3);
            put(rows, yl);
            if (yl == 2)
                rows = {{16{rows[15]}}, rows[15:0]};
            if (!rows[31])
                for (int r = 0; r < rows; r++)
                begin
                    put(rand_bin(), yl);
                    cols = small_count(xl, 3);
                    put(cols, xl);
                    if (xl == 2)
                        cols = {{16{cols[15]}}, cols[15:0]};
                    if (!cols[31])
                        for (int c = 0; c < cols; c++)
                        begin
                            put(rand_bin(), xl);
                            put((cl == 2) ? $urandom : rand_float(), cl);
                        end
                end
        end
        else if (kind_byte == cbrd_pkg::TYPE_DENSE)
        begin
            cells = small_count(4, 9);
            put(cells, 4);
            case ($urandom_range(5))
                0: put(32'd0, 2);
                1: put({16'd0, 1'b1, 15'($urandom)}, 2);
                default: put($urandom_range(4, 1), 2);
            endcase
            if (!cells[31])
                for (int i = 0; i < cells; i++)
                    if (cl == 2)
                        put(($urandom_range(4) == 0) ? {16'd0, cbrd_pkg::SHORT_SENTINEL}
                                                     : $urandom, 2);
                    else
                        put(rand_float(), 4);
        end
    endtask

    task automatic send_block(input logic cut);
        logic [15:0] c;
        int          keep;
        c = 16'($urandom);
        keep = block_bytes.size();
        // abandon part way through, the next block start restarts the parser
        if (cut && keep > 1)
            keep = $urandom_range(keep - 1, 1);
        for (int i = 0; i < keep; i++)
            send_byte(block_bytes[i], i == 0, c);
        blocks_sent++;
    endtask

    task automatic run_segment(input logic [3:0] ver, input int budget, input logic hold);
        int start_count;
        drain();
        write_version(ver);
        start_count = bytes_sent;
        while (bytes_sent - start_count < budget)
        begin
            build_block(ver);
            send_block($urandom_range(11) == 0);
            if ($urandom_range(7) == 0)
                repeat ($urandom_range(3, 1))
                    send_byte(8'($urandom), 1'b0, 16'($urandom));
            if (hold && bytes_sent - start_count > budget / 2)
            begin
                hold = 1'b0;
                drain();
            end
        end
    endtask

    initial
    begin
        logic [3:0] versions[9];
        int         waited;
        versions = '{4'd9, 4'd6, 4'd7, 4'd8, 4'd9, 4'd6, 4'd9, 4'd7, 4'd8};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // unknown type, then a dense grid at the offset extremes with a sentinel cell
        block_bytes.delete();
        put(32'd1, 4); put(32'h7FFF_FFFF, 4); put(32'h8000_0000, 4);
        put(32'd0, 1); put(32'd0, 1); put(32'd0, 1); put(32'd7, 1);
        send_block(1'b0);
        block_bytes.delete();
        put(32'd3, 4); put(32'hFFFF_FFFF, 4); put(32'h7FFF_FFFF, 4);
        put(32'd0, 1); put(32'd0, 1); put(32'd0, 1); put({24'd0, cbrd_pkg::TYPE_DENSE}, 1);
        put(32'd3, 4); put(32'd2, 2);
        put(32'h7FFF, 2); put({16'd0, cbrd_pkg::SHORT_SENTINEL}, 2); put(32'h8001, 2);
        send_block(1'b0);

        for (int s = 0; s < 9; s++)
        begin
            send_idle = (s < 3) ? 10 : (s < 6) ? 49 : 0;
            recv_idle = (s < 3) ? 49 : (s < 6) ? 10 : 0;
            run_segment(versions[s], 175, s == 1);
        end
        s_axis_tvalid <= 1'b0;

        waited = 0;
        while (pending != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (20) @(posedge clk);
        $display("covered %0d bytes in %0d blocks over versions 6 to 9", bytes_sent, blocks_sent);
        $display("checked %0d records and %0d end markers", records_seen, markers_seen);
        if (errors == 0 && pending == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

[sim.f]
src/cbrd_pkg.sv
src/cbrd_parser.sv
src/cbrd_fifo.sv
src/contact_block_record_decoder.sv
test/cbrd_record_checker.sv
test/tb_top.sv
